@@ hdl/extension_field_multiply_unit_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef EXTENSION_FIELD_MULTIPLY_UNIT_MACROS_SVH
`define EXTENSION_FIELD_MULTIPLY_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EFMU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EFMU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/efmu_pkg.sv @@
package efmu_pkg;

   localparam int DEF_MAX_DEGREE = 8;
   localparam int DEF_COEF_BITS  = 50;
   localparam int CSR_W          = 64;
   localparam int CSR_IDX_W      = 2;
   localparam int DEG_W          = 4;
   localparam int STEP_W         = 7;

   localparam logic [CSR_W-1:0] MODULUS_RESET = 64'd1125899906842597;
   localparam logic [DEG_W-1:0] DEGREE_RESET  = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODULUS = 2'd0,
      CSR_WRAP    = 2'd1,
      CSR_DEGREE  = 2'd2
   } csr_reg_type;

   typedef enum logic {
      OP_REDUCE = 1'b0,
      OP_MULMOD = 1'b1
   } mod_op_type;

   typedef struct packed {
      logic       start;
      mod_op_type op;
   } mod_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LA_GO,
      ST_LA_WAIT,
      ST_LB_GO,
      ST_LB_WAIT,
      ST_WRAP_GO,
      ST_WRAP_WAIT,
      ST_READ,
      ST_RA_GO,
      ST_RA_WAIT,
      ST_RB_GO,
      ST_RB_WAIT,
      ST_WM_GO,
      ST_WM_WAIT,
      ST_AM_GO,
      ST_AM_WAIT,
      ST_ACCUM
   } state_type;

endpackage

@@ hdl/efmu_store.sv @@
module efmu_store #(
   parameter int MAX_DEGREE = efmu_pkg::DEF_MAX_DEGREE,
   parameter int COEF_BITS  = efmu_pkg::DEF_COEF_BITS,
   parameter int IDX_BITS   = 3
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_BITS-1:0]  wr_addr,
   input  logic [COEF_BITS-1:0] wr_a,
   input  logic [COEF_BITS-1:0] wr_b,
   input  logic                 rd_en,
   input  logic [IDX_BITS-1:0]  rd_addr_a,
   input  logic [IDX_BITS-1:0]  rd_addr_b,
   output logic [COEF_BITS-1:0] rd_a,
   output logic [COEF_BITS-1:0] rd_b
);
   import efmu_pkg::*;

   logic [COEF_BITS-1:0] a_mem [MAX_DEGREE];
   logic [COEF_BITS-1:0] b_mem [MAX_DEGREE];
   logic [COEF_BITS-1:0] rd_a_ff;
   logic [COEF_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         a_mem[wr_addr] <= wr_a;
         b_mem[wr_addr] <= wr_b;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_a_ff <= a_mem[rd_addr_a];
         rd_b_ff <= b_mem[rd_addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

@@ hdl/efmu_modunit.sv @@
module efmu_modunit #(
   parameter int COEF_BITS = efmu_pkg::DEF_COEF_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  efmu_pkg::mod_cmd_type     cmd,
   input  logic [efmu_pkg::CSR_W-1:0] x,
   input  logic [COEF_BITS-1:0]      y,
   input  logic [COEF_BITS-1:0]      q,
   output efmu_pkg::mod_stat_type    stat,
   output logic [COEF_BITS-1:0]      result
);
   import efmu_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [CSR_W-1:0]     src_ff, src_in;
   logic [COEF_BITS-1:0] mul_ff, mul_in;
   mod_op_type           op_ff, op_in;
   logic [COEF_BITS-1:0] r_ff, r_in;

   logic                 bit_cur;
   logic [COEF_BITS:0]   dbl;
   logic [COEF_BITS-1:0] dbl_red;
   logic [COEF_BITS-1:0] addend;
   logic [COEF_BITS:0]   sum;
   logic [COEF_BITS-1:0] r_step;

   // one bit a step: r = 2r mod q, then add the bit's share mod q
   always_comb begin
      bit_cur = src_ff[CSR_W-1];
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, q}) ? COEF_BITS'(dbl - {1'b0, q}) : dbl[COEF_BITS-1:0];
      if (op_ff == OP_REDUCE) begin
         addend = COEF_BITS'(bit_cur);
      end else begin
         addend = bit_cur ? mul_ff : '0;
      end
      sum    = {1'b0, dbl_red} + {1'b0, addend};
      r_step = (sum >= {1'b0, q}) ? COEF_BITS'(sum - {1'b0, q}) : sum[COEF_BITS-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      src_in  = src_ff;
      mul_in  = mul_ff;
      op_in   = op_ff;
      r_in    = r_ff;
      if (cmd.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         r_in    = '0;
         mul_in  = x[COEF_BITS-1:0];
         if (cmd.op == OP_REDUCE) begin
            src_in = x;
            cnt_in = STEP_W'(CSR_W);
         end else begin
            src_in = {y, {(CSR_W-COEF_BITS){1'b0}}};
            cnt_in = STEP_W'(COEF_BITS);
         end
      end else if (busy_ff) begin
         r_in   = r_step;
         src_in = {src_ff[CSR_W-2:0], 1'b0};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      src_ff <= src_in;
      mul_ff <= mul_in;
      op_ff  <= op_in;
      r_ff   <= r_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = r_ff;

endmodule

@@ hdl/extension_field_multiply_unit.sv @@
// Multiplier in GF(q)[x]/(x^d - w). Load one coefficient pair per request
// (start high while busy is low). Each pair is reduced mod q on arrival on a
// single bit-serial modular unit, which keeps busy high until both of its
// coefficients are reduced, so a new request cannot be taken before the last
// pair is through. The d-th pair then starts the product: reduce w, then for
// each of the d*d terms read the memory, reduce the two stored coefficients
// again by the current q, multiply the b coefficient by the wrap factor when
// i > k, form the product, and accumulate. The d product coefficients come
// out on rsp_strobe, one cycle each, d terms apart, in index order 0 to d-1,
// with rsp_last_coef on the final one; busy falls in the cycle of that final
// strobe. The results cannot be stalled: capture each on the strobe. Write
// configuration only while busy is low; a degree write drops any partly
// loaded element.
`include "extension_field_multiply_unit_macros.svh"

module extension_field_multiply_unit #(
   parameter int MAX_DEGREE = efmu_pkg::DEF_MAX_DEGREE,
   parameter int COEF_BITS  = efmu_pkg::DEF_COEF_BITS,
   localparam int IDX_BITS  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [COEF_BITS-1:0]           req_a_coef,
   input  logic [COEF_BITS-1:0]           req_b_coef,
   output logic                           rsp_strobe,
   output logic [COEF_BITS-1:0]           rsp_prod_coef,
   output logic [IDX_BITS-1:0]            rsp_coef_index,
   output logic                           rsp_last_coef,
   input  logic                           csr_we,
   input  logic [efmu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [efmu_pkg::CSR_W-1:0]     csr_wdata
);
   import efmu_pkg::*;

   localparam int CNT_W = $clog2(MAX_DEGREE + 1);

   // configuration
   logic [COEF_BITS-1:0] modulus_ff;
   logic [CSR_W-1:0]     wrap_ff;
   logic [DEG_W-1:0]     degree_ff;

   // sequencer
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]     k_ff;
   logic [CNT_W-1:0]     i_ff;
   logic [COEF_BITS-1:0] acc_ff;
   logic [COEF_BITS-1:0] ws_ff;
   logic [COEF_BITS-1:0] av_ff;
   logic [COEF_BITS-1:0] bv_ff;
   logic [COEF_BITS-1:0] pv_ff;
   logic [COEF_BITS-1:0] prod_ff;

   // response register
   logic                 rsp_strobe_ff;
   logic [COEF_BITS-1:0] rsp_coef_ff;
   logic [IDX_BITS-1:0]  rsp_index_ff;
   logic                 rsp_last_ff;

   logic                 accept;
   logic                 store_we;
   logic                 last_load;
   logic [COEF_BITS-1:0] eff_q;
   logic [DEG_W-1:0]     deg_clip;
   logic [CNT_W-1:0]     eff_d;
   logic [CNT_W-1:0]     j_idx;
   logic                 wrapped;
   logic                 last_i;
   logic                 last_k;
   logic [COEF_BITS:0]   acc_sum;
   logic [COEF_BITS-1:0] acc_new;

   mod_cmd_type          mu_cmd;
   mod_stat_type         mu_stat;
   logic [CSR_W-1:0]     mu_x;
   logic [COEF_BITS-1:0] mu_y;
   logic [COEF_BITS-1:0] mu_res;
   logic                 rd_en;
   logic [COEF_BITS-1:0] rd_a;
   logic [COEF_BITS-1:0] rd_b;

   // a modulus of zero behaves as one; clamp the degree into 1..MAX_DEGREE
   always_comb begin
      eff_q = (modulus_ff == '0) ? COEF_BITS'(1) : modulus_ff;
      if (degree_ff == '0) begin
         deg_clip = DEG_W'(1);
      end else if (degree_ff > DEG_W'(MAX_DEGREE)) begin
         deg_clip = DEG_W'(MAX_DEGREE);
      end else begin
         deg_clip = degree_ff;
      end
      eff_d = CNT_W'(deg_clip);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   // the reduced pair is written as the second reduction finishes
   assign store_we  = (state_ff == ST_LB_WAIT) && mu_stat.done;
   assign last_load = ((fill_ff + CNT_W'(1)) == eff_d);
   assign wrapped   = (i_ff > k_ff);
   assign last_i    = (i_ff == eff_d - CNT_W'(1));
   assign last_k    = (k_ff == eff_d - CNT_W'(1));
   assign j_idx     = (k_ff >= i_ff) ? (k_ff - i_ff) : (k_ff + eff_d - i_ff);
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, prod_ff};
   assign acc_new   = (acc_sum >= {1'b0, eff_q}) ? COEF_BITS'(acc_sum - {1'b0, eff_q})
                                                 : acc_sum[COEF_BITS-1:0];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[COEF_BITS-1:0];
         wrap_ff    <= '0;
         degree_ff  <= DEGREE_RESET;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            CSR_MODULUS: modulus_ff <= csr_wdata[COEF_BITS-1:0];
            CSR_WRAP:    wrap_ff    <= csr_wdata;
            CSR_DEGREE:  degree_ff  <= csr_wdata[DEG_W-1:0];
            default:     ;
         endcase
      end
   end

   // fill count: restart on a degree write, wrap after the last pair
   always_comb begin
      fill_in = fill_ff;
      if (csr_we && (csr_reg_type'(csr_index) == CSR_DEGREE)) begin
         fill_in = '0;
      end else if (store_we) begin
         fill_in = last_load ? '0 : fill_ff + CNT_W'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (accept) state_in = ST_LA_GO;
         ST_LA_GO:     state_in = ST_LA_WAIT;
         ST_LA_WAIT:   if (mu_stat.done) state_in = ST_LB_GO;
         ST_LB_GO:     state_in = ST_LB_WAIT;
         ST_LB_WAIT: begin
            if (mu_stat.done) state_in = last_load ? ST_WRAP_GO : ST_IDLE;
         end
         ST_WRAP_GO:   state_in = ST_WRAP_WAIT;
         ST_WRAP_WAIT: if (mu_stat.done) state_in = ST_READ;
         ST_READ:      state_in = ST_RA_GO;
         ST_RA_GO:     state_in = ST_RA_WAIT;
         ST_RA_WAIT:   if (mu_stat.done) state_in = ST_RB_GO;
         ST_RB_GO:     state_in = ST_RB_WAIT;
         ST_RB_WAIT: begin
            if (mu_stat.done) state_in = wrapped ? ST_WM_GO : ST_AM_GO;
         end
         ST_WM_GO:     state_in = ST_WM_WAIT;
         ST_WM_WAIT:   if (mu_stat.done) state_in = ST_AM_GO;
         ST_AM_GO:     state_in = ST_AM_WAIT;
         ST_AM_WAIT:   if (mu_stat.done) state_in = ST_ACCUM;
         ST_ACCUM:     state_in = (last_i && last_k) ? ST_IDLE : ST_READ;
         default:      state_in = ST_IDLE;
      endcase
   end

   // unit commands and memory reads
   always_comb begin
      mu_cmd.start = 1'b0;
      mu_cmd.op    = OP_REDUCE;
      mu_x         = '0;
      mu_y         = '0;
      rd_en        = 1'b0;
      unique case (state_ff)
         ST_LA_GO: begin
            mu_cmd.start = 1'b1;
            mu_x         = CSR_W'(av_ff);
         end
         ST_LB_GO: begin
            mu_cmd.start = 1'b1;
            mu_x         = CSR_W'(bv_ff);
         end
         ST_WRAP_GO: begin
            mu_cmd.start = 1'b1;
            mu_x         = wrap_ff;
         end
         ST_READ: begin
            rd_en = 1'b1;
         end
         ST_RA_GO: begin
            mu_cmd.start = 1'b1;
            mu_x         = CSR_W'(rd_a);
         end
         ST_RB_GO: begin
            mu_cmd.start = 1'b1;
            mu_x         = CSR_W'(rd_b);
         end
         ST_WM_GO: begin
            mu_cmd.start = 1'b1;
            mu_cmd.op    = OP_MULMOD;
            mu_x         = CSR_W'(ws_ff);
            mu_y         = bv_ff;
         end
         ST_AM_GO: begin
            mu_cmd.start = 1'b1;
            mu_cmd.op    = OP_MULMOD;
            mu_x         = CSR_W'(av_ff);
            mu_y         = pv_ff;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= (state_ff == ST_ACCUM) && last_i;
      end
   end

   // datapath registers: hold the raw pair, capture unit results, advance the term indexes
   always_ff @(posedge clock) begin
      if (accept) begin
         av_ff <= req_a_coef;
         bv_ff <= req_b_coef;
      end
      if (store_we && last_load) begin
         k_ff   <= '0;
         i_ff   <= '0;
         acc_ff <= '0;
      end
      if (mu_stat.done) begin
         unique case (state_ff)
            ST_LA_WAIT:   av_ff <= mu_res;
            ST_WRAP_WAIT: ws_ff <= mu_res;
            ST_RA_WAIT:   av_ff <= mu_res;
            ST_RB_WAIT: begin
               bv_ff <= mu_res;
               pv_ff <= mu_res;
            end
            ST_WM_WAIT:   pv_ff <= mu_res;
            ST_AM_WAIT:   prod_ff <= mu_res;
            default: ;
         endcase
      end
      if (state_ff == ST_ACCUM) begin
         if (last_i) begin
            rsp_coef_ff  <= acc_new;
            rsp_index_ff <= k_ff[IDX_BITS-1:0];
            rsp_last_ff  <= last_k;
            acc_ff       <= '0;
            i_ff         <= '0;
            k_ff         <= k_ff + CNT_W'(1);
         end else begin
            acc_ff <= acc_new;
            i_ff   <= i_ff + CNT_W'(1);
         end
      end
   end

   efmu_store #(
      .MAX_DEGREE (MAX_DEGREE),
      .COEF_BITS  (COEF_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_store (
      .clock     (clock),
      .wr_en     (store_we),
      .wr_addr   (fill_ff[IDX_BITS-1:0]),
      .wr_a      (av_ff),
      .wr_b      (mu_res),
      .rd_en     (rd_en),
      .rd_addr_a (i_ff[IDX_BITS-1:0]),
      .rd_addr_b (j_idx[IDX_BITS-1:0]),
      .rd_a      (rd_a),
      .rd_b      (rd_b)
   );

   efmu_modunit #(
      .COEF_BITS (COEF_BITS)
   ) u_modunit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mu_cmd),
      .x      (mu_x),
      .y      (mu_y),
      .q      (eff_q),
      .stat   (mu_stat),
      .result (mu_res)
   );

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_prod_coef  = rsp_coef_ff;
   assign rsp_coef_index = rsp_index_ff;
   assign rsp_last_coef  = rsp_last_ff;

   `EFMU_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "request not taken")
   `EFMU_ASSERT_SAME(a_last_coef_idle, clock, reset, rsp_strobe_ff && rsp_last_ff, state_ff == ST_IDLE, "busy after last coefficient")
   `EFMU_ASSERT_SAME(a_unit_free, clock, reset, mu_cmd.start, !mu_stat.busy, "unit started while busy")

endmodule
